// ===== design/vrt_pkg.sv =====
// Shared types, constants and helper functions of the voxel ray traversal block.
package vrt_pkg;

  localparam int unsigned CELL_W = 11;
  localparam int unsigned T_W    = 24;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned DEN_W  = 16;
  localparam int unsigned SQ_W   = 32;

  localparam logic [T_W-1:0] T_INF     = 24'hFFFFFF;
  localparam logic [15:0]    REACH_RST = 16'd2048;
  localparam logic [1:0]     BLOCK_AIR = 2'd0;
  localparam logic           REG_REACH = 1'b0;
  localparam logic           KIND_WRITE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_CHK,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WT,
    ST_AXIS,
    ST_TMAX_GO,
    ST_TMAX_WT,
    ST_TDLT_WT,
    ST_CHK,
    ST_STEP,
    ST_DONE
  } vrt_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } vrt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } vrt_div_rsp_t;

  // Quotients at or above the infinity code saturate to it.
  function automatic logic [T_W-1:0] sat_t(input logic [NUM_W-1:0] q);
    return (q >= NUM_W'(T_INF)) ? T_INF : q[T_W-1:0];
  endfunction

  // Saturating add of ray parameters; infinity stays infinity.
  function automatic logic [T_W-1:0] add_t(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
    logic [T_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == T_INF || b == T_INF) return T_INF;
    return (s >= {1'b0, T_INF}) ? T_INF : s[T_W-1:0];
  endfunction

endpackage

// ===== design/vrt_in_if.sv =====
// Input channel of the voxel ray traversal block.
interface vrt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         vox_x;
  logic [4:0]         vox_y;
  logic [4:0]         vox_z;
  logic [1:0]         block_id;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic signed [15:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (
    output valid, kind, vox_x, vox_y, vox_z, block_id,
    output origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, kind, vox_x, vox_y, vox_z, block_id,
    input  origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

// ===== design/vrt_out_if.sv =====
// Result channel of the voxel ray traversal block.
interface vrt_out_if;
  logic              valid;
  logic              ready;
  logic              hit;
  logic              changed;
  logic [4:0]        hit_x;
  logic [4:0]        hit_y;
  logic [4:0]        hit_z;
  logic signed [6:0] prev_x;
  logic signed [6:0] prev_y;
  logic signed [6:0] prev_z;

  modport source (
    output valid, hit, changed, hit_x, hit_y, hit_z, prev_x, prev_y, prev_z,
    input  ready
  );
  modport sink (
    input  valid, hit, changed, hit_x, hit_y, hit_z, prev_x, prev_y, prev_z,
    output ready
  );
endinterface

// ===== design/vrt_store.sv =====
// Voxel id memory with one read and one write port and a clearing pass after reset.
module vrt_store #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  output logic          busy_o
);
  import vrt_pkg::*;

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_q;
  logic [AW-1:0] clr_q;
  logic          busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= BLOCK_AIR;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;
  assign busy_o  = busy_q;
endmodule

// ===== design/vrt_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module vrt_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vrt_pkg::SQ_W-1:0]   value_i,
  output logic                       done_o,
  output logic [vrt_pkg::LEN_W-1:0] root_o
);
  import vrt_pkg::*;

  logic [SQ_W-1:0] v_q, res_q, bit_q;
  logic            busy_q, done_q;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == SQ_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_q   <= v_q - trial[SQ_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LEN_W-1:0];
endmodule

// ===== design/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vrt_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vrt_pkg::vrt_div_req_t req_i,
  output vrt_pkg::vrt_div_rsp_t rsp_o
);
  import vrt_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] nq_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      nq_q  <= req_i.num;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = nq_q;
endmodule

// ===== design/voxel_ray_traversal_top.sv =====
// Top level of the voxel ray traversal block: control sequencer, ray setup and voxel walk.
// The block keeps a GRID_SIZE^3 grid of two-bit block ids in one synchronous memory and
// handles one item at a time. After reset a clearing pass writes air to every entry; no
// item is accepted during it, while the reach register can be written at any time. A write
// beat reads the entry, compares it and writes it back. A cast beat first sums the squared
// direction components, takes the square root in an iterative unit, and then, for every
// axis with a nonzero component, runs two divisions through one shared divider. The walk
// then spends, for every voxel stepped, one memory read and one check. A finished result
// sits in an output register, and a new beat is accepted while it waits to be taken.
module voxel_ray_traversal_top #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:2]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  vrt_in_if.sink       in_i,
  vrt_out_if.source    out_o
);
  import vrt_pkg::*;

  localparam int unsigned DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(GRID_SIZE);

  typedef logic signed [CELL_W-1:0] cell_t;

  // Cells inside 0..GRID_SIZE-1 on an axis.
  function automatic logic in_grid(input cell_t c);
    return !c[CELL_W-1] && (c < CELL_W'(GRID_SIZE));
  endfunction

  function automatic logic [AW-1:0] vox_idx(input cell_t x, input cell_t y, input cell_t z);
    return AW'(x[PW-1:0]) + AW'(y[PW-1:0]) * AW'(GRID_SIZE) +
           AW'(z[PW-1:0]) * AW'(GRID_SIZE * GRID_SIZE);
  endfunction

  vrt_state_e state_q, state_d;

  logic [15:0]        reach_q;
  logic [1:0]         bid_q;
  logic [1:0]         ax_q;
  logic signed [15:0] dir_q  [3];
  logic [15:0]        ad_q   [3];
  logic [8:0]         nxt_q  [3];
  logic [2:0]         neg_q, dz_q;
  cell_t              cell_q [3];
  cell_t              prev_q [3];
  logic [T_W-1:0]     tmax_q [3];
  logic [T_W-1:0]     tdlt_q [3];
  logic [SQ_W-1:0]    sq_q;
  logic [LEN_W-1:0]   len_q;
  logic [T_W-1:0]     prod_q;
  logic               res_hit_q, res_chg_q;

  logic               ov_q, o_hit_q, o_chg_q;
  logic [4:0]         o_hx_q, o_hy_q, o_hz_q;
  logic [6:0]         o_px_q, o_py_q, o_pz_q;

  logic               in_ready, in_acc, out_load, mem_we, sqrt_start, sqrt_done;
  logic [LEN_W-1:0]   sqrt_root;
  vrt_div_req_t       div_req;
  vrt_div_rsp_t       div_rsp;
  logic [1:0]         rd_data;
  logic               clr_busy;
  logic [AW-1:0]      raddr;
  cell_t              cell_d [3];
  cell_t              cell_nx [3];
  cell_t              ld_cell [3];
  logic signed [15:0] in_dir [3];
  logic signed [15:0] in_org [3];
  logic signed [31:0] sqp;
  logic               wr_ok, dir_nz, solid, miss;
  logic [2:0]         sel;
  logic [T_W-1:0]     tsel, dsel, tnew;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REACH) ? {16'd0, reach_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= REACH_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_REACH) begin
      reach_q <= pwdata[15:0];
    end
  end

  // ---------------- input decode ----------------
  assign in_dir[0] = in_i.dir_x;
  assign in_dir[1] = in_i.dir_y;
  assign in_dir[2] = in_i.dir_z;
  assign in_org[0] = in_i.origin_x;
  assign in_org[1] = in_i.origin_y;
  assign in_org[2] = in_i.origin_z;

  assign wr_ok = (8'(in_i.vox_x) < 8'(GRID_SIZE)) && (8'(in_i.vox_y) < 8'(GRID_SIZE)) &&
                 (8'(in_i.vox_z) < 8'(GRID_SIZE));
  assign dir_nz = (in_i.dir_x != '0) || (in_i.dir_y != '0) || (in_i.dir_z != '0);

  always_comb begin
    if (in_i.kind == KIND_WRITE) begin
      ld_cell[0] = CELL_W'(in_i.vox_x);
      ld_cell[1] = CELL_W'(in_i.vox_y);
      ld_cell[2] = CELL_W'(in_i.vox_z);
    end else begin
      for (int a = 0; a < 3; a++) begin
        // The cell is the origin rounded toward minus infinity.
        ld_cell[a] = {{(CELL_W - 8){in_org[a][15]}}, in_org[a][15:8]};
      end
    end
  end

  assign in_ready = (state_q == ST_IDLE) && !clr_busy;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // ---------------- walk step ----------------
  // Smallest crossing wins; ties fall to z, except that a tie of x and y below z goes to y.
  always_comb begin
    sel = 3'b000;
    if (tmax_q[0] < tmax_q[1] && tmax_q[0] < tmax_q[2]) begin
      sel[0] = 1'b1;
    end else if (tmax_q[0] >= tmax_q[1] && tmax_q[1] < tmax_q[2]) begin
      sel[1] = 1'b1;
    end else begin
      sel[2] = 1'b1;
    end
    tsel = sel[0] ? tmax_q[0] : (sel[1] ? tmax_q[1] : tmax_q[2]);
    dsel = sel[0] ? tdlt_q[0] : (sel[1] ? tdlt_q[1] : tdlt_q[2]);
    tnew = add_t(tsel, dsel);
    for (int a = 0; a < 3; a++) begin
      if (sel[a]) begin
        cell_nx[a] = neg_q[a] ? cell_q[a] - CELL_W'(1) : cell_q[a] + CELL_W'(1);
      end else begin
        cell_nx[a] = cell_q[a];
      end
    end
  end

  assign miss  = tsel > {4'd0, reach_q, 4'd0};
  assign solid = in_grid(cell_q[0]) && in_grid(cell_q[1]) && in_grid(cell_q[2]) &&
                 (rd_data != BLOCK_AIR);

  // The memory is addressed with the coming cell so its data lines up with the cell register.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (state_q == ST_IDLE) begin
        cell_d[a] = ld_cell[a];
      end else if (state_q == ST_STEP) begin
        cell_d[a] = cell_nx[a];
      end else begin
        cell_d[a] = cell_q[a];
      end
    end
  end

  assign raddr = vox_idx(cell_d[0], cell_d[1], cell_d[2]);
  assign sqp   = dir_q[ax_q] * dir_q[ax_q];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    sqrt_start   = 1'b0;
    div_req.start = 1'b0;
    div_req.num  = {prod_q, 4'd0};
    div_req.den  = ad_q[ax_q];
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == KIND_WRITE) begin
            state_d = wr_ok ? ST_WR_CHK : ST_DONE;
          end else begin
            state_d = dir_nz ? ST_SQ : ST_DONE;
          end
        end
      end
      ST_WR_CHK: begin
        mem_we  = (rd_data != bid_q);
        state_d = ST_DONE;
      end
      ST_SQ: begin
        if (ax_q == 2'd2) state_d = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_WT;
      end
      ST_SQRT_WT: begin
        if (sqrt_done) state_d = ST_AXIS;
      end
      ST_AXIS: begin
        if (!dz_q[ax_q]) begin
          state_d = ST_TMAX_GO;
        end else if (ax_q == 2'd2) begin
          state_d = ST_CHK;
        end
      end
      ST_TMAX_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_TMAX_WT;
      end
      ST_TMAX_WT: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = {len_q, 12'd0};
          state_d       = ST_TDLT_WT;
        end
      end
      ST_TDLT_WT: begin
        if (div_rsp.done) state_d = (ax_q == 2'd2) ? ST_CHK : ST_AXIS;
      end
      ST_CHK: begin
        state_d = solid ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        state_d = miss ? ST_DONE : ST_CHK;
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Axis counter shared by the square sum and the per-axis setup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE:    ax_q <= '0;
        ST_SQ:      ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        ST_AXIS:    if (dz_q[ax_q] && ax_q != 2'd2) ax_q <= ax_q + 2'd1;
        ST_TDLT_WT: if (div_rsp.done && ax_q != 2'd2) ax_q <= ax_q + 2'd1;
        default:    ax_q <= ax_q;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          bid_q     <= in_i.block_id;
          sq_q      <= '0;
          res_hit_q <= 1'b0;
          res_chg_q <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            cell_q[a] <= ld_cell[a];
            prev_q[a] <= ld_cell[a];
            dir_q[a]  <= in_dir[a];
            ad_q[a]   <= in_dir[a][15] ? 16'(~in_dir[a] + 16'sd1) : in_dir[a];
            neg_q[a]  <= in_dir[a][15];
            dz_q[a]   <= (in_dir[a] == '0);
            // Distance to the next boundary in the stepping direction.
            nxt_q[a]  <= in_dir[a][15] ? {1'b0, in_org[a][7:0]}
                                        : 9'd256 - {1'b0, in_org[a][7:0]};
          end
        end
      end
      ST_WR_CHK: res_chg_q <= (rd_data != bid_q);
      ST_SQ:     sq_q <= sq_q + unsigned'(sqp);
      ST_SQRT_WT: if (sqrt_done) len_q <= sqrt_root;
      ST_AXIS: begin
        if (dz_q[ax_q]) begin
          tmax_q[ax_q] <= T_INF;
          tdlt_q[ax_q] <= T_INF;
        end else begin
          prod_q <= T_W'(nxt_q[ax_q] * len_q);
        end
      end
      ST_TMAX_WT: if (div_rsp.done) tmax_q[ax_q] <= sat_t(div_rsp.quot);
      ST_TDLT_WT: if (div_rsp.done) tdlt_q[ax_q] <= sat_t(div_rsp.quot);
      ST_CHK:     if (solid) res_hit_q <= 1'b1;
      ST_STEP: begin
        for (int a = 0; a < 3; a++) begin
          prev_q[a] <= cell_q[a];
          cell_q[a] <= cell_nx[a];
          if (sel[a]) tmax_q[a] <= tnew;
        end
      end
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_hit_q <= res_hit_q;
      o_chg_q <= res_chg_q;
      o_hx_q  <= res_hit_q ? cell_q[0][4:0] : 5'd0;
      o_hy_q  <= res_hit_q ? cell_q[1][4:0] : 5'd0;
      o_hz_q  <= res_hit_q ? cell_q[2][4:0] : 5'd0;
      o_px_q  <= res_hit_q ? prev_q[0][6:0] : 7'd0;
      o_py_q  <= res_hit_q ? prev_q[1][6:0] : 7'd0;
      o_pz_q  <= res_hit_q ? prev_q[2][6:0] : 7'd0;
    end
  end

  assign out_o.valid   = ov_q;
  assign out_o.hit     = o_hit_q;
  assign out_o.changed = o_chg_q;
  assign out_o.hit_x   = o_hx_q;
  assign out_o.hit_y   = o_hy_q;
  assign out_o.hit_z   = o_hz_q;
  assign out_o.prev_x  = o_px_q;
  assign out_o.prev_y  = o_py_q;
  assign out_o.prev_z  = o_pz_q;

  // ---------------- units ----------------
  vrt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .rdata_o (rd_data),
    .we_i    (mem_we),
    .waddr_i (vox_idx(cell_q[0], cell_q[1], cell_q[2])),
    .wdata_i (bid_q),
    .busy_o  (clr_busy)
  );

  vrt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  vrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );
endmodule

// ===== design/vrt_checker.sv =====
// Port-level assertions for the voxel ray traversal block and their binding.
module vrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic       out_changed,
  input logic [4:0] hit_x,
  input logic [4:0] hit_y,
  input logic [4:0] hit_z,
  input logic [6:0] prev_x,
  input logic [6:0] prev_y,
  input logic [6:0] prev_z
);

  // The sequencer leaves idle as soon as a beat is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  // No result can be produced in the cycle right after acceptance.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early after acceptance");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_hit) |-> (hit_x == 5'd0 && hit_y == 5'd0 && hit_z == 5'd0 &&
                                 prev_x == 7'd0 && prev_y == 7'd0 && prev_z == 7'd0))
    else $error("coordinates nonzero on a result without a hit");

  a_hit_or_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_hit && out_changed))
    else $error("hit and changed both set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit)))
    else $error("stalled result beat dropped or changed");

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_hit     (out_o.hit),
  .out_changed (out_o.changed),
  .hit_x       (out_o.hit_x),
  .hit_y       (out_o.hit_y),
  .hit_z       (out_o.hit_z),
  .prev_x      (out_o.prev_x),
  .prev_y      (out_o.prev_y),
  .prev_z      (out_o.prev_z)
);

// ===== bench/tb_voxel_ray_traversal_top.sv =====
// Self-checking testbench of the voxel ray traversal block.
`timescale 1ns / 1ps

module tb_voxel_ray_traversal_top;
  import vrt_pkg::*;

  localparam int unsigned GRID      = 32;
  localparam int unsigned CYCLE_MAX = 3000000;
  localparam int unsigned SETTLE    = 400;

  // One input beat as the sender builds it.
  typedef struct packed {
    logic               kind;
    logic [4:0]         vx;
    logic [4:0]         vy;
    logic [4:0]         vz;
    logic [1:0]         id;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } ray_beat_t;

  // One result beat, laid out field by field as on the output channel.
  typedef struct packed {
    logic              hit;
    logic              changed;
    logic [4:0]        hx;
    logic [4:0]        hy;
    logic [4:0]        hz;
    logic signed [6:0] px;
    logic signed [6:0] py;
    logic signed [6:0] pz;
  } trace_res_t;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  vrt_in_if  ray_in ();
  vrt_out_if ray_out ();

  voxel_ray_traversal_top #(.GRID_SIZE(GRID)) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (ray_in),
    .out_o   (ray_out)
  );

  // Shadow copy of the block state: the voxel grid and the reach register.
  logic [1:0]  grid_ids [GRID*GRID*GRID];
  logic [15:0] reach_q;

  // Results the block still owes, oldest first.
  trace_res_t  pending_hits[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Ray parameters are unsigned Q12.12 in 24 bits, all ones being
  // infinity; every quotient or sum at or above it saturates.
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] clamp_t(input longint unsigned v);
    return (v >= 64'(T_INF)) ? T_INF : v[23:0];
  endfunction

  function automatic logic [23:0] advance_t(input logic [23:0] a, input logic [23:0] b);
    if (a == T_INF || b == T_INF) return T_INF;
    return clamp_t(longint'(a) + longint'(b));
  endfunction

  // Floor of the square root, digit by digit.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned acc, bit_w;
    acc = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= acc + bit_w) begin
        v -= acc + bit_w;
        acc = (acc >> 1) + bit_w;
      end else begin
        acc >>= 1;
      end
      bit_w >>= 2;
    end
    return acc;
  endfunction

  function automatic logic [1:0] voxel_at(input int x, input int y, input int z);
    if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID) return BLOCK_AIR;
    return grid_ids[x + y*GRID + z*GRID*GRID];
  endfunction

  // Starting cell, step sign, first boundary crossing and crossing spacing of one axis.
  task automatic axis_start(input logic signed [15:0] o, input logic signed [15:0] d,
                            input longint unsigned len, output int start_cell,
                            output int stp, output logic [23:0] t_next,
                            output logic [23:0] t_span);
    int o_i, frac;
    longint unsigned mag, gap;
    o_i  = int'(o);
    frac = o_i & 255;
    start_cell = o_i >>> 8;
    if (d == 0) begin
      stp = 0;
      t_next = T_INF;
      t_span = T_INF;
    end else begin
      stp    = (d > 0) ? 1 : -1;
      mag    = (d > 0) ? longint'(d) : -longint'(d);
      gap    = 64'((d > 0) ? 256 - frac : frac);
      t_next = clamp_t(gap * 16 * len / mag);
      t_span = clamp_t(len * 4096 / mag);
    end
  endtask

  // Works out the result of one accepted beat and applies writes to the shadow grid.
  task automatic trace_beat(input ray_beat_t b, output trace_res_t r);
    int cx, cy, cz, sx, sy, sz, qx, qy, qz;
    logic [23:0] tx, ty, tz, ex, ey, ez, t_hit, lim;
    longint unsigned len;
    int idx;
    r = '0;
    if (b.kind == KIND_WRITE) begin
      idx = b.vx + b.vy*GRID + b.vz*GRID*GRID;
      if (grid_ids[idx] != b.id) begin
        grid_ids[idx] = b.id;
        r.changed = 1'b1;
      end
      return;
    end
    // A ray without direction never leaves its origin and counts as a miss.
    if (b.dx == 0 && b.dy == 0 && b.dz == 0) return;
    len = floor_root(longint'(int'(b.dx) * int'(b.dx)) + longint'(int'(b.dy) * int'(b.dy))
                     + longint'(int'(b.dz) * int'(b.dz)));
    axis_start(b.ox, b.dx, len, cx, sx, tx, ex);
    axis_start(b.oy, b.dy, len, cy, sy, ty, ey);
    axis_start(b.oz, b.dz, len, cz, sz, tz, ez);
    qx = cx; qy = cy; qz = cz;
    // A solid start voxel is its own hit, with the previous voxel equal to it.
    if (voxel_at(cx, cy, cz) == BLOCK_AIR) begin
      lim = 24'(reach_q) << 4;
      forever begin
        qx = cx; qy = cy; qz = cz;
        // Ties go to z, except that x and y tied below z go to y; y wins over z only when strictly smaller.
        if (tx < ty && tx < tz) begin
          cx += sx; t_hit = tx; tx = advance_t(tx, ex);
        end else if (tx >= ty && ty < tz) begin
          cy += sy; t_hit = ty; ty = advance_t(ty, ey);
        end else begin
          cz += sz; t_hit = tz; tz = advance_t(tz, ez);
        end
        if (t_hit > lim) return;
        if (voxel_at(cx, cy, cz) != BLOCK_AIR) break;
      end
    end
    r.hit = 1'b1;
    r.hx = cx[4:0]; r.hy = cy[4:0]; r.hz = cz[4:0];
    r.px = qx[6:0]; r.py = qy[6:0]; r.pz = qz[6:0];
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers. Inputs change at the falling edge, sampling happens at the
  // rising edge, so the testbench never races the block.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input ray_beat_t b);
    trace_res_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      ray_in.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    ray_in.valid    = 1'b1;
    ray_in.kind     = b.kind;
    ray_in.vox_x    = b.vx;
    ray_in.vox_y    = b.vy;
    ray_in.vox_z    = b.vz;
    ray_in.block_id = b.id;
    ray_in.origin_x = b.ox;
    ray_in.origin_y = b.oy;
    ray_in.origin_z = b.oz;
    ray_in.dir_x    = b.dx;
    ray_in.dir_y    = b.dy;
    ray_in.dir_z    = b.dz;
    do @(posedge clk); while (!ray_in.ready);
    // The beat is taken at this edge; predict now so writes land in order.
    trace_beat(b, r);
    pending_hits = {pending_hits, r};
    @(negedge clk);
  endtask

  // Lets every owed result come back before the line is reused or reconfigured.
  task automatic drain;
    ray_in.valid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input logic [2:2] addr, input logic [31:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == REG_REACH) reach_q = data[15:0];
  endtask

  function automatic ray_beat_t voxel_write(input int x, input int y, input int z,
                                            input int id);
    ray_beat_t b;
    b = '0;
    b.kind = ~KIND_WRITE;
    b.kind = KIND_WRITE;
    b.vx = 5'(x); b.vy = 5'(y); b.vz = 5'(z); b.id = 2'(id);
    return b;
  endfunction

  function automatic ray_beat_t ray_cast(input int ox, input int oy, input int oz,
                                         input int dx, input int dy, input int dz);
    ray_beat_t b;
    b = '0;
    b.kind = ~KIND_WRITE;
    b.ox = 16'(ox); b.oy = 16'(oy); b.oz = 16'(oz);
    b.dx = 16'(dx); b.dy = 16'(dy); b.dz = 16'(dz);
    return b;
  endfunction

  // Random beat. Writes cluster in a small cube so that most rays, which also
  // start near it, run into something within reach. The rest roams freely.
  function automatic ray_beat_t random_beat;
    ray_beat_t b;
    logic [15:0] d [3];
    logic [15:0] o [3];
    b = '0;
    if ($urandom_range(99) < 40) begin
      b.kind = KIND_WRITE;
      if ($urandom_range(3) == 0) begin
        b.vx = 5'($urandom); b.vy = 5'($urandom); b.vz = 5'($urandom);
      end else begin
        b.vx = 5'($urandom_range(8, 15)); b.vy = 5'($urandom_range(8, 15));
        b.vz = 5'($urandom_range(8, 15));
      end
      b.id = 2'($urandom);
      return b;
    end
    b.kind = ~KIND_WRITE;
    for (int a = 0; a < 3; a++) begin
      o[a] = ($urandom_range(9) < 7) ? 16'($urandom_range(4*256, 20*256 - 1)) : 16'($urandom);
      case ($urandom_range(7))
        0:       d[a] = 16'h0000;
        1:       d[a] = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        2:       d[a] = 16'($signed(16'($urandom_range(0, 64))) - 16'sd32);
        default: d[a] = 16'($urandom);
      endcase
    end
    // An all-zero direction should stay rare.
    if (d[0] == 0 && d[1] == 0 && d[2] == 0 && $urandom_range(3) != 0) d[0] = 16'h4000;
    b.ox = o[0]; b.oy = o[1]; b.oz = o[2];
    b.dx = d[0]; b.dy = d[1]; b.dz = d[2];
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every result beat is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    ray_out.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    trace_res_t got, want;
    if (rst_n && ray_out.valid && ray_out.ready) begin
      got = '{ray_out.hit, ray_out.changed, ray_out.hit_x, ray_out.hit_y, ray_out.hit_z,
              ray_out.prev_x, ray_out.prev_y, ray_out.prev_z};
      if (pending_hits.size() == 0) begin
        $display("%0t: result beat with nothing expected: hit=%0b changed=%0b", $realtime,
                 got.hit, got.changed);
        fail_cnt++;
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected hit=%0b chg=%0b at=(%0d,%0d,%0d) prev=(%0d,%0d,%0d)",
                   $realtime, want.hit, want.changed, want.hx, want.hy, want.hz,
                   want.px, want.py, want.pz);
          $display("%0t:             actual hit=%0b chg=%0b at=(%0d,%0d,%0d) prev=(%0d,%0d,%0d)",
                   $realtime, got.hit, got.changed, got.hx, got.hy, got.hz,
                   got.px, got.py, got.pz);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog; the limit covers the clearing pass and the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Writes at the grid corners, rewrites of the same id, and clearing back to air.
  task automatic test_voxel_writes;
    send_beat(voxel_write(0, 0, 0, 3));
    send_beat(voxel_write(0, 0, 0, 3));
    send_beat(voxel_write(31, 31, 31, 2));
    send_beat(voxel_write(31, 31, 31, 0));
    send_beat(voxel_write(31, 31, 31, 0));
    send_beat(voxel_write(10, 10, 10, 1));
    send_beat(voxel_write(12, 10, 10, 2));
    send_beat(voxel_write(10, 12, 12, 1));
  endtask

  // Special rays: zero direction, solid start, ties, axis rays, extremes.
  task automatic test_special_rays;
    send_beat(ray_cast(10*256 + 128, 10*256, 10*256, 0, 0, 0));
    send_beat(ray_cast(10*256 + 128, 10*256 + 7, 10*256 + 200, 100, -3, 9));
    send_beat(ray_cast(8*256, 10*256 + 128, 10*256 + 128, 16384, 0, 0));
    send_beat(ray_cast(14*256, 10*256 + 128, 10*256 + 128, -16384, 0, 0));
    send_beat(ray_cast(10*256 + 128, 10*256 + 128, 9*256 + 128, 4096, 4096, 4096));
    send_beat(ray_cast(9*256 + 128, 9*256 + 128, 10*256 + 128, 8192, 8192, 0));
    send_beat(ray_cast(10*256, 9*256, 11*256, 0, 16384, 16384));
    send_beat(ray_cast(-32768, -32768, -32768, 32767, 32767, 32767));
    send_beat(ray_cast(32767, 32767, 32767, -32768, -32768, -32768));
    send_beat(ray_cast(-256, 0, 0, 32767, 1, 0));
    send_beat(ray_cast(0, 0, 32*256 + 50, 0, 0, -32768));
    send_beat(ray_cast(10*256 + 128, 2*256, 10*256 + 128, 0, 1, 0));
    send_beat(ray_cast(5*256, 5*256, 5*256, -1, -1, -1));
    send_beat(ray_cast(20*256, 20*256, 20*256, 1234, -5678, 3000));
  endtask

  task automatic test_random_traffic(input int unsigned beats, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) send_beat(random_beat());
    drain();
  endtask

  // Reach at both ends of its range, plus a write to the unused register slot.
  task automatic test_reach_extremes;
    apb_write(1'b1, 32'h0000_0001);
    apb_write(REG_REACH, 32'h0000_0000);
    test_random_traffic(30, 0, 0);
    apb_write(REG_REACH, 32'h0000_FFFF);
    test_random_traffic(20, 31, 31);
    apb_write(REG_REACH, 32'(REACH_RST));
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ray_in.valid = 1'b0; ray_in.kind = KIND_WRITE;
    ray_in.vox_x = '0; ray_in.vox_y = '0; ray_in.vox_z = '0; ray_in.block_id = '0;
    ray_in.origin_x = '0; ray_in.origin_y = '0; ray_in.origin_z = '0;
    ray_in.dir_x = '0; ray_in.dir_y = '0; ray_in.dir_z = '0;
    ray_out.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    fail_cnt = 0; cycle_cnt = 0;
    foreach (grid_ids[i]) grid_ids[i] = BLOCK_AIR;
    reach_q = REACH_RST;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The block ignores beats until its clearing pass is over; the sender
    // simply waits for ready.
    test_voxel_writes();
    test_special_rays();
    drain();

    // The sender holds back here until every result has come home.
    apb_write(REG_REACH, 32'd4096);
    test_random_traffic(420, 0, 0);
    apb_write(REG_REACH, 32'd1024);
    test_random_traffic(400, 76, 0);
    apb_write(REG_REACH, 32'd2048);
    test_random_traffic(400, 0, 76);
    apb_write(REG_REACH, 32'd6000);
    test_random_traffic(400, 31, 31);
    test_reach_extremes();

    repeat (SETTLE) @(negedge clk);
    if (fail_cnt == 0 && pending_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
